### hdl/hsv_to_rgb_led_duty_unit_defines.svh
// Assertion macros for the HSV to RGB LED duty unit.
// Used by the pipeline modules; no other dependencies.
`ifndef HSV_TO_RGB_LED_DUTY_UNIT_DEFINES_SVH
`define HSV_TO_RGB_LED_DUTY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HSVRGB_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSVRGB_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

### hdl/hsvrgb_pkg.sv
// Shared types and constants of the HSV to RGB LED duty pipeline.
// No dependencies.
package hsvrgb_pkg;

    localparam logic [12:0] HUE_FULL     = 13'd5760;
    localparam logic [9:0]  SECTOR_CODES = 10'd960;
    localparam logic [7:0]  FULL_SCALE   = 8'd255;
    localparam logic [17:0] Q_DEN        = 18'd244800;
    // 244800 = 64 * 3825: drop six bits, then divide by 3825
    localparam int          Q_PRE_SHIFT  = 6;
    localparam logic [11:0] Q_DIV        = 12'd3825;
    // floor(2^32 / 3825) and floor(2^24 / 255)
    localparam logic [20:0] Q_RECIP      = 21'd1122867;
    localparam logic [16:0] P_RECIP      = 17'd65793;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic        off;
        t_sector     sector;
        logic [9:0]  frac;
        logic [7:0]  sat;
        logic [7:0]  val;
    } t_sec_data;

    typedef struct packed {
        logic        off;
        t_sector     sector;
        logic [7:0]  val;
        logic [15:0] num_p;
        logic [17:0] fs;
        logic [17:0] gs;
    } t_prod_data;

    typedef struct packed {
        logic        off;
        t_sector     sector;
        logic [7:0]  val;
        logic [15:0] num_p;
        logic [19:0] num_q;
        logic [19:0] num_t;
    } t_num_data;

    typedef struct packed {
        logic        off;
        t_sector     sector;
        logic [7:0]  val;
        logic [15:0] num_p;
        logic [19:0] num_q;
        logic [19:0] num_t;
        logic [7:0]  est_p;
        logic [7:0]  est_q;
        logic [7:0]  est_t;
    } t_est_data;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic logic [12:0] sector_base(input t_sector sec);
        logic [12:0] base;
        case (sec)
            SEC_RY:  base = 13'd0;
            SEC_YG:  base = 13'd960;
            SEC_GC:  base = 13'd1920;
            SEC_CB:  base = 13'd2880;
            SEC_BM:  base = 13'd3840;
            SEC_MR:  base = 13'd4800;
            default: base = 13'd0;
        endcase
        return base;
    endfunction

endpackage

### hdl/hsv_to_rgb_led_duty_unit.sv
// HSV to RGB LED duty unit: five-stage pipeline, hue/saturation/value in,
// red/green/blue PWM duties out. Depends on hsvrgb_pkg and the stage modules.
// Throughput: one request per cycle; per-stage ready fills bubbles under stall.
// Each stage register holds one request.
// Reset clears the stage valid bits only; data registers are not reset.
module hsv_to_rgb_led_duty_unit
    import hsvrgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [13:0] hue (signed), [21:14] saturation, [29:22] brightness, [31:30] zero
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty
    output logic [23:0] o_m_axis_tdata
);

    logic      w_sec_vld;
    logic      w_sec_rdy;
    t_sec_data w_sec_data;
    logic      w_num_vld;
    logic      w_num_rdy;
    t_num_data w_num_data;
    t_rgb      w_rgb;

    hsvrgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_hue   (i_s_axis_tdata[13:0]),
        .i_sat   (i_s_axis_tdata[21:14]),
        .i_val   (i_s_axis_tdata[29:22]),
        .o_valid (w_sec_vld),
        .i_ready (w_sec_rdy),
        .o_data  (w_sec_data)
    );

    hsvrgb_product u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sec_vld),
        .o_ready (w_sec_rdy),
        .i_data  (w_sec_data),
        .o_valid (w_num_vld),
        .i_ready (w_num_rdy),
        .o_data  (w_num_data)
    );

    hsvrgb_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_num_vld),
        .o_ready (w_num_rdy),
        .i_data  (w_num_data),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_rgb)
    );

    assign o_m_axis_tdata = {w_rgb.blue, w_rgb.green, w_rgb.red};

endmodule

### hdl/hsvrgb_sector.sv
// Stage 1: wraps the hue, splits it into sector and offset, flags the off code.
// Depends on hsvrgb_pkg and the assertion macro header.
`include "hsv_to_rgb_led_duty_unit_defines.svh"
module hsvrgb_sector
    import hsvrgb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [13:0]       i_hue,
    input  logic [7:0]        i_sat,
    input  logic [7:0]        i_val,
    output logic              o_valid,
    input  logic              i_ready,
    output t_sec_data         o_data
);

    logic        r_vld;
    t_sec_data   r_data;
    t_sec_data   n_data;
    logic [12:0] w_hue;
    t_sector     w_sec;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        // hue past the full circle folds back by one turn
        if (i_hue[12:0] >= HUE_FULL) begin
            w_hue = i_hue[12:0] - HUE_FULL;
        end else begin
            w_hue = i_hue[12:0];
        end
        if (w_hue >= 13'd4800) begin
            w_sec = SEC_MR;
        end else if (w_hue >= 13'd3840) begin
            w_sec = SEC_BM;
        end else if (w_hue >= 13'd2880) begin
            w_sec = SEC_CB;
        end else if (w_hue >= 13'd1920) begin
            w_sec = SEC_GC;
        end else if (w_hue >= 13'd960) begin
            w_sec = SEC_YG;
        end else begin
            w_sec = SEC_RY;
        end
        n_data.off    = i_hue[13];
        n_data.sector = w_sec;
        n_data.frac   = 10'(w_hue - sector_base(w_sec));
        n_data.sat    = i_sat;
        n_data.val    = i_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

    `HSVRGB_ASSERT(a_neg_hue_off, i_clk, i_rst_n,
        (i_valid && o_ready && i_hue[13]) |=> (r_vld && r_data.off),
        "negative hue request did not raise the off flag")

endmodule

### hdl/hsvrgb_product.sv
// Stages 2 and 3: forms the p numerator and the scaled q and t numerators.
// Depends on hsvrgb_pkg and the assertion macro header.
`include "hsv_to_rgb_led_duty_unit_defines.svh"
module hsvrgb_product
    import hsvrgb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_sec_data         i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_num_data         o_data
);

    logic        r_vld2;
    logic        r_vld3;
    t_prod_data  r_d2;
    t_prod_data  n_d2;
    t_num_data   r_d3;
    t_num_data   n_d3;
    logic        w_rdy2;
    logic        w_rdy3;
    logic [25:0] w_xq;
    logic [25:0] w_xt;

    assign w_rdy3  = !r_vld3 || i_ready;
    assign w_rdy2  = !r_vld2 || w_rdy3;
    assign o_ready = w_rdy2;

    always_comb begin
        n_d2.off    = i_data.off;
        n_d2.sector = i_data.sector;
        n_d2.val    = i_data.val;
        n_d2.num_p  = 16'(i_data.val) * 16'(FULL_SCALE - i_data.sat);
        n_d2.fs     = 18'(i_data.frac) * 18'(i_data.sat);
        n_d2.gs     = 18'(SECTOR_CODES - i_data.frac) * 18'(i_data.sat);
    end

    always_comb begin
        w_xq        = 26'(r_d2.val) * 26'(Q_DEN - r_d2.fs);
        w_xt        = 26'(r_d2.val) * 26'(Q_DEN - r_d2.gs);
        n_d3.off    = r_d2.off;
        n_d3.sector = r_d2.sector;
        n_d3.val    = r_d2.val;
        n_d3.num_p  = r_d2.num_p;
        n_d3.num_q  = w_xq[25:Q_PRE_SHIFT];
        n_d3.num_t  = w_xt[25:Q_PRE_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_vld2 <= i_valid;
            end
            if (w_rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy2) begin
            r_d2 <= n_d2;
        end
        if (r_vld2 && w_rdy3) begin
            r_d3 <= n_d3;
        end
    end

    assign o_valid = r_vld3;
    assign o_data  = r_d3;

    `HSVRGB_ASSERT(a_stall_hold, i_clk, i_rst_n,
        (r_vld3 && !i_ready) |=> (r_vld3 && $stable(r_d3)),
        "stage 3 request changed while stalled")

endmodule

### hdl/hsvrgb_divide.sv
// Stages 4 and 5: reciprocal quotient estimates, one-step correction,
// channel ordering by sector. Depends on hsvrgb_pkg and the macro header.
`include "hsv_to_rgb_led_duty_unit_defines.svh"
module hsvrgb_divide
    import hsvrgb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_num_data         i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_rgb              o_data
);

    logic        r_vld4;
    logic        r_vld5;
    t_est_data   r_d4;
    t_est_data   n_d4;
    t_rgb        r_d5;
    t_rgb        n_d5;
    logic        w_rdy4;
    logic        w_rdy5;
    logic [32:0] w_pp;
    logic [40:0] w_pq;
    logic [40:0] w_pt;
    logic [15:0] w_rem_p;
    logic [19:0] w_rem_q;
    logic [19:0] w_rem_t;
    logic [7:0]  w_p;
    logic [7:0]  w_q;
    logic [7:0]  w_t;
    logic [7:0]  w_v;

    assign w_rdy5  = !r_vld5 || i_ready;
    assign w_rdy4  = !r_vld4 || w_rdy5;
    assign o_ready = w_rdy4;

    // estimates land on the true quotient or one below
    always_comb begin
        w_pp         = 33'(i_data.num_p) * 33'(P_RECIP);
        w_pq         = 41'(i_data.num_q) * 41'(Q_RECIP);
        w_pt         = 41'(i_data.num_t) * 41'(Q_RECIP);
        n_d4.off     = i_data.off;
        n_d4.sector  = i_data.sector;
        n_d4.val     = i_data.val;
        n_d4.num_p   = i_data.num_p;
        n_d4.num_q   = i_data.num_q;
        n_d4.num_t   = i_data.num_t;
        n_d4.est_p   = w_pp[31:24];
        n_d4.est_q   = w_pq[39:32];
        n_d4.est_t   = w_pt[39:32];
    end

    always_comb begin
        w_rem_p = r_d4.num_p - 16'(r_d4.est_p) * 16'(FULL_SCALE);
        w_rem_q = r_d4.num_q - 20'(r_d4.est_q) * 20'(Q_DIV);
        w_rem_t = r_d4.num_t - 20'(r_d4.est_t) * 20'(Q_DIV);
        w_p = r_d4.est_p + 8'(w_rem_p >= 16'(FULL_SCALE));
        w_q = r_d4.est_q + 8'(w_rem_q >= 20'(Q_DIV));
        w_t = r_d4.est_t + 8'(w_rem_t >= 20'(Q_DIV));
        w_v = r_d4.val;
        case (r_d4.sector)
            SEC_RY:  n_d5 = '{red: w_v, green: w_t, blue: w_p};
            SEC_YG:  n_d5 = '{red: w_q, green: w_v, blue: w_p};
            SEC_GC:  n_d5 = '{red: w_p, green: w_v, blue: w_t};
            SEC_CB:  n_d5 = '{red: w_p, green: w_q, blue: w_v};
            SEC_BM:  n_d5 = '{red: w_t, green: w_p, blue: w_v};
            default: n_d5 = '{red: w_v, green: w_p, blue: w_q};
        endcase
        // drop all channels for negative hue
        if (r_d4.off) begin
            n_d5 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (w_rdy4) begin
                r_vld4 <= i_valid;
            end
            if (w_rdy5) begin
                r_vld5 <= r_vld4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy4) begin
            r_d4 <= n_d4;
        end
        if (r_vld4 && w_rdy5) begin
            r_d5 <= n_d5;
        end
    end

    assign o_valid = r_vld5;
    assign o_data  = r_d5;

    `HSVRGB_ASSERT(a_rem_q_range, i_clk, i_rst_n,
        r_vld4 |-> (w_rem_q < {7'd0, Q_DIV, 1'b0}),
        "q quotient estimate off by more than one")
    `HSVRGB_ASSERT(a_rem_p_range, i_clk, i_rst_n,
        r_vld4 |-> (w_rem_p < {7'd0, FULL_SCALE, 1'b0}),
        "p quotient estimate off by more than one")

endmodule
